// File: design/tsb_pkg.sv
// ============================================================================
// Tilt-shift blend package
// Shared widths, payload types, register indexes and the tanh lookup table.
// ============================================================================
package tsb_pkg;

   // Field and register widths.
   localparam int ROW_W    = 12;
   localparam int PIX_W    = 8;
   localparam int TOP_W    = 12;
   localparam int HEIGHT_W = 13;
   localparam int SOFT_W   = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_BAND_TOP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BAND_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SOFTNESS    = 2'd2;

   localparam logic [TOP_W-1:0]    BAND_TOP_RST    = 12'd0;
   localparam logic [HEIGHT_W-1:0] BAND_HEIGHT_RST = 13'd20;
   localparam logic [SOFT_W-1:0]   SOFTNESS_RST    = 7'd6;

   // Rows above MAX_ROWS-1 are treated as the last row.
   localparam int MAX_ROWS = 4096;

   // Signed distance from the band edges: row - top - 2*(height/2).
   localparam int DIST_W = 15;

   // Tanh argument in Q3.12, clamped to 4.0.
   localparam int ARG_ONE_SHIFT = 12;
   localparam int ARG_LIMIT     = 4 * (1 << ARG_ONE_SHIFT);
   localparam int ARG_HALF      = ARG_LIMIT / 2;
   localparam int QUOT_W        = $clog2(ARG_LIMIT);
   localparam int QUOT_HALF     = QUOT_W / 2;
   localparam int SMALL_W       = SOFT_W + 2;
   localparam int NUM_W         = SMALL_W + ARG_ONE_SHIFT;
   localparam int ARG_W         = QUOT_W + 1;

   // Q15 formats.
   localparam int Q15_ONE  = 32768;
   localparam int Q15_HALF = Q15_ONE / 2;
   localparam int TANH_W   = 16;
   localparam int ALPHA_W  = 16;

   localparam int TANH_TABLE_SIZE = 256;
   localparam int IDX_W = $clog2(TANH_TABLE_SIZE + 1);

   typedef logic [TANH_W-1:0] tanh_tab_type [0:TANH_TABLE_SIZE];

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [PIX_W-1:0] sharp_b;
      logic [PIX_W-1:0] sharp_g;
      logic [PIX_W-1:0] sharp_r;
      logic [PIX_W-1:0] soft_b;
      logic [PIX_W-1:0] soft_g;
      logic [PIX_W-1:0] soft_r;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_b;
      logic [PIX_W-1:0] out_g;
      logic [PIX_W-1:0] out_r;
   } rsp_type;

   // Unsigned long division by shift and subtract, used only while the
   // table is built at elaboration.
   function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
         r = (r << 1) | ((n >> b) & 64'd1);
         if (r >= d) begin
            r = r - d;
            q = q | (64'd1 << b);
         end
      end
      return q;
   endfunction

   // tanh(4*i/TANH_TABLE_SIZE) in Q15: exp by Taylor series in Q24, squared
   // three times, then (E-1)/(E+1). Evaluated at elaboration only.
   function automatic logic [TANH_W-1:0] tanh_entry(int unsigned i);
      longint unsigned one;
      longint unsigned u;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned k;
      longint unsigned res;
      one  = 64'd1 << 24;
      u    = udiv64((64'(i) << 24) + 64'(TANH_TABLE_SIZE >> 1), 64'(TANH_TABLE_SIZE));
      term = one;
      sum  = one;
      for (k = 1; k <= 24; k++) begin
         if (term != 0) begin
            term = udiv64((term * u) >> 24, k);
            sum  = sum + term;
         end
      end
      for (int s = 0; s < 3; s++) begin
         sum = (sum * sum) >> 24;
      end
      if (sum < one) begin
         sum = one;
      end
      res = udiv64((sum - one) * 64'(Q15_ONE) + ((sum + one) >> 1), sum + one);
      return res[TANH_W-1:0];
   endfunction

   function automatic tanh_tab_type build_tanh_tab();
      tanh_tab_type tab;
      for (int i = 0; i <= TANH_TABLE_SIZE; i++) begin
         tab[i] = tanh_entry(i);
      end
      return tab;
   endfunction

   localparam tanh_tab_type TANH_TAB = build_tanh_tab();

endpackage

// File: design/tsb_tanh_lane.sv
// ============================================================================
// Tilt-shift tanh lane
// Four-stage tanh of a signed row distance over the softness divisor.
// ============================================================================
module tsb_tanh_lane (
   input  logic                                 clock,
   input  logic [3:0]                           stage_en,
   input  logic signed [tsb_pkg::DIST_W-1:0]    delta,
   input  logic [tsb_pkg::SOFT_W-1:0]           divisor,
   output logic signed [tsb_pkg::TANH_W:0]      tanh_val
);

   localparam int SW = tsb_pkg::SOFT_W;
   localparam int QH = tsb_pkg::QUOT_HALF;
   localparam int QW = tsb_pkg::QUOT_W;

   // One restoring division step: returns {quotient bit, new remainder}.
   function automatic logic [SW:0] div_step(logic [SW-1:0] rem, logic nb,
                                            logic [SW-1:0] d);
      logic [SW:0] sh;
      logic [SW:0] diff;
      sh   = {rem, nb};
      diff = sh - {1'b0, d};
      if (sh >= {1'b0, d}) begin
         return {1'b1, diff[SW-1:0]};
      end else begin
         return {1'b0, sh[SW-1:0]};
      end
   endfunction

   // Stage 1: sign, magnitude, saturation and the dividend.
   logic                           neg1_ff, neg1_in;
   logic                           sat1_ff, sat1_in;
   logic [SW-1:0]                  rem1_ff, rem1_in;
   logic [QW-1:0]                  low1_ff, low1_in;

   logic [tsb_pkg::DIST_W-1:0]     neg_dist;
   logic [tsb_pkg::DIST_W-2:0]     mag;
   logic [tsb_pkg::NUM_W-1:0]      num;

   always_comb begin
      neg1_in  = delta[tsb_pkg::DIST_W-1];
      neg_dist = tsb_pkg::DIST_W'(-delta);
      mag      = neg1_in ? neg_dist[tsb_pkg::DIST_W-2:0] : delta[tsb_pkg::DIST_W-2:0];
      // The quotient reaches the 4.0 clamp exactly when |n| >= 4*d.
      sat1_in  = mag >= (tsb_pkg::DIST_W-1)'({divisor, 2'b00});
      num      = (tsb_pkg::NUM_W'(mag[tsb_pkg::SMALL_W-1:0]) << tsb_pkg::ARG_ONE_SHIFT)
                 | tsb_pkg::NUM_W'(divisor >> 1);
      rem1_in  = num[tsb_pkg::NUM_W-1:QW];
      low1_in  = num[QW-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         neg1_ff <= neg1_in;
         sat1_ff <= sat1_in;
         rem1_ff <= rem1_in;
         low1_ff <= low1_in;
      end
   end

   // Stage 2: upper half of the quotient bits.
   logic                neg2_ff, sat2_ff;
   logic [SW-1:0]       rem2_ff, rem2_in;
   logic [QH-1:0]       qhi2_ff, qhi2_in;
   logic [QW-QH-1:0]    low2_ff;

   always_comb begin
      logic [SW:0] st;
      logic [SW-1:0] r;
      r = rem1_ff;
      qhi2_in = '0;
      for (int i = 0; i < QH; i++) begin
         st = div_step(r, low1_ff[QW-1-i], divisor);
         qhi2_in[QH-1-i] = st[SW];
         r = st[SW-1:0];
      end
      rem2_in = r;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         neg2_ff <= neg1_ff;
         sat2_ff <= sat1_ff;
         rem2_ff <= rem2_in;
         qhi2_ff <= qhi2_in;
         low2_ff <= low1_ff[QW-QH-1:0];
      end
   end

   // Stage 3: lower half of the quotient bits.
   logic                neg3_ff, sat3_ff;
   logic [QW-1:0]       quot3_ff, quot3_in;

   always_comb begin
      logic [SW:0] st;
      logic [SW-1:0] r;
      logic [QW-QH-1:0] qlo;
      r = rem2_ff;
      qlo = '0;
      for (int i = 0; i < QW - QH; i++) begin
         st = div_step(r, low2_ff[QW-QH-1-i], divisor);
         qlo[QW-QH-1-i] = st[SW];
         r = st[SW-1:0];
      end
      quot3_in = {qhi2_ff, qlo};
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         neg3_ff  <= neg2_ff;
         sat3_ff  <= sat2_ff;
         quot3_ff <= quot3_in;
      end
   end

   // Stage 4: table index, lookup and sign.
   logic signed [tsb_pkg::TANH_W:0] tanh_in;
   logic [tsb_pkg::ARG_W-1:0]       arg;
   logic [31:0]                     idx_full;
   logic [tsb_pkg::IDX_W-1:0]       idx;
   logic [tsb_pkg::TANH_W:0]        mag_t;

   always_comb begin
      arg = sat3_ff ? tsb_pkg::ARG_W'(tsb_pkg::ARG_LIMIT) : tsb_pkg::ARG_W'(quot3_ff);
      idx_full = (32'(arg) * 32'(tsb_pkg::TANH_TABLE_SIZE) + 32'(tsb_pkg::ARG_HALF))
                 >> QW;
      if (idx_full > 32'(tsb_pkg::TANH_TABLE_SIZE)) begin
         idx = tsb_pkg::IDX_W'(tsb_pkg::TANH_TABLE_SIZE);
      end else begin
         idx = idx_full[tsb_pkg::IDX_W-1:0];
      end
      mag_t   = {1'b0, tsb_pkg::TANH_TAB[idx]};
      tanh_in = neg3_ff ? -$signed(mag_t) : $signed(mag_t);
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         tanh_val <= tanh_in;
      end
   end

endmodule

// File: design/tsb_mix.sv
// ============================================================================
// Tilt-shift channel mix
// Registered blend of one sharp and one blurred channel by a Q15 weight.
// ============================================================================
module tsb_mix (
   input  logic                           clock,
   input  logic                           stage_en,
   input  logic [tsb_pkg::PIX_W-1:0]      sharp,
   input  logic [tsb_pkg::PIX_W-1:0]      blur,
   input  logic [tsb_pkg::ALPHA_W-1:0]    alpha,
   output logic [tsb_pkg::PIX_W-1:0]      mixed
);

   logic [tsb_pkg::ALPHA_W-1:0] beta;
   logic [24:0]                 acc;
   logic [9:0]                  scaled;
   logic [tsb_pkg::PIX_W-1:0]   mixed_in;

   always_comb begin
      beta   = tsb_pkg::ALPHA_W'(tsb_pkg::Q15_ONE) - alpha;
      acc    = 25'(sharp) * 25'(alpha) + 25'(blur) * 25'(beta)
               + 25'(tsb_pkg::Q15_HALF);
      scaled = acc[24:15];
      mixed_in = (scaled > 10'd255) ? 8'd255 : scaled[tsb_pkg::PIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         mixed <= mixed_in;
      end
   end

endmodule

// File: design/tilt_shift_blend.sv
// ============================================================================
// Tilt-shift band blend
// Blends a sharp and a blurred pixel by a tanh-shaped row weight.
// ============================================================================
// Each req word carries one pixel: its row and its sharp and blurred BGR
// values. Each rsp word carries the blended BGR pixel, one per req word and
// in the same order. Both channels use valid/ready.
// The pipeline is seven stages deep. One pixel is accepted every cycle
// while the output is not stalled; the depth is set mostly by the two tanh
// lanes, whose divide by the softness register is split over two stages of
// seven quotient bits. When the receiver stalls, each stage holds its word
// and stages behind it keep filling any empty slots, so req_ready drops
// only once every stage is occupied. Reset empties the pipeline and loads
// the registers with their defaults (top 0, height 20, softness 6). The csr
// port writes a register when csr_we is high; it should only be written
// while no pixel is in flight.
// ============================================================================
module tilt_shift_blend (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tsb_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tsb_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [tsb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tsb_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int STAGES = 7;
   localparam int ALPHA_STAGE = 5;

   // Configuration registers.
   logic [tsb_pkg::TOP_W-1:0]    band_top_ff;
   logic [tsb_pkg::HEIGHT_W-1:0] band_height_ff;
   logic [tsb_pkg::SOFT_W-1:0]   softness_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_top_ff    <= tsb_pkg::BAND_TOP_RST;
         band_height_ff <= tsb_pkg::BAND_HEIGHT_RST;
         softness_ff    <= tsb_pkg::SOFTNESS_RST;
      end else if (csr_we) begin
         case (csr_index)
            tsb_pkg::REG_BAND_TOP: begin
               band_top_ff <= csr_wdata[tsb_pkg::TOP_W-1:0];
            end
            tsb_pkg::REG_BAND_HEIGHT: begin
               band_height_ff <= csr_wdata[tsb_pkg::HEIGHT_W-1:0];
            end
            tsb_pkg::REG_SOFTNESS: begin
               softness_ff <= csr_wdata[tsb_pkg::SOFT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // A softness of zero behaves as one.
   logic [tsb_pkg::SOFT_W-1:0] divisor;
   assign divisor = (softness_ff == '0) ? tsb_pkg::SOFT_W'(1) : softness_ff;

   // Stage occupancy and the ready chain: a stage may load when it is empty
   // or when its word moves on in the same cycle.
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] load;

   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (load[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = load[0];
   assign rsp_valid = valid_ff[STAGES-1];

   // Stage 0: distances from the two band edges.
   logic signed [tsb_pkg::DIST_W-1:0] dist_a_ff, dist_a_in;
   logic signed [tsb_pkg::DIST_W-1:0] dist_b_ff, dist_b_in;
   logic [tsb_pkg::ROW_W-1:0]         row_c;
   logic [tsb_pkg::HEIGHT_W-1:0]      band_span;

   always_comb begin
      if (32'(req_data.row) > 32'(tsb_pkg::MAX_ROWS - 1)) begin
         row_c = tsb_pkg::ROW_W'(tsb_pkg::MAX_ROWS - 1);
      end else begin
         row_c = req_data.row;
      end
      // Twice the integer half height.
      band_span = {band_height_ff[tsb_pkg::HEIGHT_W-1:1], 1'b0};
      dist_a_in = $signed(tsb_pkg::DIST_W'(row_c)) - $signed(tsb_pkg::DIST_W'(band_top_ff));
      dist_b_in = dist_a_in - $signed(tsb_pkg::DIST_W'(band_span));
   end

   // Pixel values ride alongside the lanes, one register per stage.
   tsb_pkg::req_type pix_ff [0:ALPHA_STAGE];

   always_ff @(posedge clock) begin
      if (load[0]) begin
         dist_a_ff <= dist_a_in;
         dist_b_ff <= dist_b_in;
         pix_ff[0] <= req_data;
      end
      for (int k = 1; k <= ALPHA_STAGE; k++) begin
         if (load[k]) begin
            pix_ff[k] <= pix_ff[k-1];
         end
      end
   end

   // Stages 1 to 4: the two tanh lanes, one per band edge.
   logic signed [tsb_pkg::TANH_W:0] tanh_a;
   logic signed [tsb_pkg::TANH_W:0] tanh_b;

   tsb_tanh_lane u_lane_a (
      .clock    (clock),
      .stage_en (load[4:1]),
      .delta    (dist_a_ff),
      .divisor  (divisor),
      .tanh_val (tanh_a)
   );

   tsb_tanh_lane u_lane_b (
      .clock    (clock),
      .stage_en (load[4:1]),
      .delta    (dist_b_ff),
      .divisor  (divisor),
      .tanh_val (tanh_b)
   );

   // Stage 5: merge the lanes into the Q15 weight
   // alpha = (tanhA - tanhB + 1) / 2, zero if negative, at most one.
   logic [tsb_pkg::ALPHA_W-1:0]       alpha_ff, alpha_in;
   logic signed [tsb_pkg::TANH_W+1:0] tanh_diff;
   logic [tsb_pkg::TANH_W+1:0]        half_diff;

   always_comb begin
      tanh_diff = (tsb_pkg::TANH_W+2)'(tanh_a) - (tsb_pkg::TANH_W+2)'(tanh_b);
      half_diff = (tsb_pkg::TANH_W+2)'(tanh_diff + 1) >> 1;
      if (tanh_diff < 0) begin
         alpha_in = '0;
      end else if (half_diff > (tsb_pkg::TANH_W+2)'(tsb_pkg::Q15_ONE)) begin
         alpha_in = tsb_pkg::ALPHA_W'(tsb_pkg::Q15_ONE);
      end else begin
         alpha_in = half_diff[tsb_pkg::ALPHA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load[ALPHA_STAGE]) begin
         alpha_ff <= alpha_in;
      end
   end

   // Stage 6: one mix lane per color channel; their registers are the output.
   tsb_mix u_mix_b (
      .clock    (clock),
      .stage_en (load[STAGES-1]),
      .sharp    (pix_ff[ALPHA_STAGE].sharp_b),
      .blur     (pix_ff[ALPHA_STAGE].soft_b),
      .alpha    (alpha_ff),
      .mixed    (rsp_data.out_b)
   );

   tsb_mix u_mix_g (
      .clock    (clock),
      .stage_en (load[STAGES-1]),
      .sharp    (pix_ff[ALPHA_STAGE].sharp_g),
      .blur     (pix_ff[ALPHA_STAGE].soft_g),
      .alpha    (alpha_ff),
      .mixed    (rsp_data.out_g)
   );

   tsb_mix u_mix_r (
      .clock    (clock),
      .stage_en (load[STAGES-1]),
      .sharp    (pix_ff[ALPHA_STAGE].sharp_r),
      .blur     (pix_ff[ALPHA_STAGE].soft_r),
      .alpha    (alpha_ff),
      .mixed    (rsp_data.out_r)
   );

endmodule

// File: tb/tilt_shift_blend_tb.sv
// ----------------------------------------------------------------------------
// Tilt-shift band blend testbench
// Streams pixels through the blend pipeline under several band settings. A
// predictor alongside the block forms the expected blended pixel for every
// accepted word, and each returned word is compared channel by channel.
// ----------------------------------------------------------------------------
module tilt_shift_blend_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Fixed-point constants of the row weight.
   localparam int TANH_STEPS = 256;      // tanh table spans 0..4.0 in this many steps
   localparam longint ARG_UNIT  = 4096;  // 1.0 in Q3.12
   localparam longint ARG_CLAMP = 16384; // 4.0 in Q3.12
   localparam int unsigned Q15_UNIT = 32768;
   localparam int SETTLE_CYCLES = 16;    // pipeline is seven stages deep
   localparam int HOLD_OFF_CYCLES = 60;  // long output stall to fill the pipeline

   // -------------------------------------------------------------------------
   // Blend predictor with its own copy of the band registers and tanh table.
   // -------------------------------------------------------------------------
   class blend_ledger;
      int unsigned      band_top;
      int unsigned      band_height;
      int unsigned      softness;
      int unsigned      tanh_q15 [0:TANH_STEPS];
      tsb_pkg::rsp_type blended_q [$];
      int unsigned      mismatches;
      int unsigned      checked;

      function new();
         for (int i = 0; i <= TANH_STEPS; i++) begin
            tanh_q15[i] = tanh_point(i);
         end
         band_top    = 0;
         band_height = 20;
         softness    = 6;
         mismatches  = 0;
         checked     = 0;
      endfunction

      // tanh(4*i/TANH_STEPS) in Q15. exp(i/TANH_STEPS) comes from a Taylor
      // series in Q24 and is squared three times to reach exp(8*i/TANH_STEPS).
      function int unsigned tanh_point(int unsigned i);
         longint unsigned one_q24;
         longint unsigned u;
         longint unsigned term;
         longint unsigned acc;
         one_q24 = 64'd1 << 24;
         u = ((64'(i) << 24) + 64'(TANH_STEPS / 2)) / 64'(TANH_STEPS);
         term = one_q24;
         acc  = one_q24;
         for (int k = 1; k <= 24 && term != 0; k++) begin
            term = ((term * u) >> 24) / 64'(k);
            acc  = acc + term;
         end
         repeat (3) acc = (acc * acc) >> 24;
         if (acc < one_q24) begin
            acc = one_q24;
         end
         return int'(((acc - one_q24) * 64'(Q15_UNIT) + (acc + one_q24) / 2)
                     / (acc + one_q24));
      endfunction

      // Signed Q15 tanh of the quotient num/den, rounded into Q3.12 and clamped.
      function int tanh_at(longint num, longint den);
         longint unsigned mag;
         longint unsigned arg;
         longint unsigned idx;
         mag = (num < 0) ? -num : num;
         arg = (mag * 64'(ARG_UNIT) + 64'(den / 2)) / 64'(den);
         if (arg > 64'(ARG_CLAMP)) begin
            arg = ARG_CLAMP;
         end
         idx = (arg * TANH_STEPS + 64'(ARG_CLAMP / 2)) / 64'(ARG_CLAMP);
         if (idx > TANH_STEPS) begin
            idx = TANH_STEPS;
         end
         return (num < 0) ? -int'(tanh_q15[idx]) : int'(tanh_q15[idx]);
      endfunction

      function logic [tsb_pkg::PIX_W-1:0] mix(int unsigned sharp, int unsigned blur,
                                              int unsigned alpha);
         int unsigned v;
         v = (sharp * alpha + blur * (Q15_UNIT - alpha) + Q15_UNIT / 2) >> 15;
         return (v > 255) ? 8'hFF : v[tsb_pkg::PIX_W-1:0];
      endfunction

      function tsb_pkg::rsp_type blend_of(tsb_pkg::req_type px);
         longint half;
         longint den;
         longint x;
         int ta;
         int tb;
         int unsigned alpha;
         tsb_pkg::rsp_type res;
         half = band_height / 2;
         den  = (softness == 0) ? 1 : softness;
         x    = longint'(px.row) - (longint'(band_top) + half);
         ta   = tanh_at(x + half, den);
         tb   = tanh_at(x - half, den);
         alpha = (ta >= tb) ? (ta - tb + 1) >> 1 : 0;
         if (alpha > Q15_UNIT) begin
            alpha = Q15_UNIT;
         end
         res.out_b = mix(px.sharp_b, px.soft_b, alpha);
         res.out_g = mix(px.sharp_g, px.soft_g, alpha);
         res.out_r = mix(px.sharp_r, px.soft_r, alpha);
         return res;
      endfunction

      function void note_pixel(tsb_pkg::req_type px);
         blended_q.push_back(blend_of(px));
      endfunction

      task flag_mismatch(string what);
         mismatches++;
         $display("MISMATCH @%0t: %s", $time, what);
      endtask

      task check_pixel(tsb_pkg::rsp_type got);
         tsb_pkg::rsp_type want;
         if (blended_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected word %h", got));
            return;
         end
         want = blended_q.pop_front();
         checked++;
         if (got.out_b !== want.out_b) begin
            flag_mismatch($sformatf("word %0d out_b %0d, want %0d",
                                    checked, got.out_b, want.out_b));
         end
         if (got.out_g !== want.out_g) begin
            flag_mismatch($sformatf("word %0d out_g %0d, want %0d",
                                    checked, got.out_g, want.out_g));
         end
         if (got.out_r !== want.out_r) begin
            flag_mismatch($sformatf("word %0d out_r %0d, want %0d",
                                    checked, got.out_r, want.out_r));
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Block and its signals.
   // -------------------------------------------------------------------------
   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   tsb_pkg::req_type               req_data;
   logic                           rsp_valid;
   logic                           rsp_ready;
   tsb_pkg::rsp_type               rsp_data;
   logic                           csr_we;
   logic [tsb_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [tsb_pkg::CSR_DATA_W-1:0] csr_wdata;

   tilt_shift_blend DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   blend_ledger ledger;

   // Pacing controls shared between the sending and receiving processes.
   bit          burst_send;       // sender offers words back to back
   bit          burst_recv;       // receiver never drops ready
   int          hold_off;         // one-shot long output stall request
   int          longest_hold;
   int unsigned sent;
   int unsigned settings;
   int unsigned backpressure;     // cycles with a word offered but refused

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Both handshakes are observed at the clock edge, so the predictor sees
   // the words in exactly the order the block takes and returns them.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            ledger.note_pixel(req_data);
         end
         if (req_valid && !req_ready) begin
            backpressure++;
         end
         if (rsp_valid && rsp_ready) begin
            ledger.check_pixel(rsp_data);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers.
   // -------------------------------------------------------------------------
   function automatic tsb_pkg::req_type pixel(int unsigned row,
                                     int unsigned sb, int unsigned sg, int unsigned sr,
                                     int unsigned bb, int unsigned bg, int unsigned br);
      tsb_pkg::req_type px;
      px.row     = tsb_pkg::ROW_W'(row);
      px.sharp_b = tsb_pkg::PIX_W'(sb);
      px.sharp_g = tsb_pkg::PIX_W'(sg);
      px.sharp_r = tsb_pkg::PIX_W'(sr);
      px.soft_b  = tsb_pkg::PIX_W'(bb);
      px.soft_g  = tsb_pkg::PIX_W'(bg);
      px.soft_r  = tsb_pkg::PIX_W'(br);
      return px;
   endfunction

   // A channel value that leans on the extremes now and then.
   function automatic logic [tsb_pkg::PIX_W-1:0] chan();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return tsb_pkg::PIX_W'($urandom);
      endcase
   endfunction

   // Most rows fall on or near the band, where the weight actually varies;
   // the rest are spread over the whole frame.
   function automatic int unsigned pick_row();
      int span;
      int lo;
      int hi;
      int den;
      if ($urandom_range(0, 9) < 3) begin
         return $urandom_range(0, tsb_pkg::MAX_ROWS - 1);
      end
      den  = (ledger.softness == 0) ? 1 : ledger.softness;
      span = 4 * den + 4;
      lo   = int'(ledger.band_top) - span;
      hi   = int'(ledger.band_top) + 2 * int'(ledger.band_height / 2) + span;
      if (lo < 0) begin
         lo = 0;
      end
      if (hi > tsb_pkg::MAX_ROWS - 1) begin
         hi = tsb_pkg::MAX_ROWS - 1;
      end
      return $urandom_range(hi, lo);
   endfunction

   // Offer one word, after an optional idle gap, and wait until it is taken.
   // Valid is only lowered when a gap follows, so back-to-back words keep it
   // high without a second assignment in the same step.
   task automatic offer_pixel(input tsb_pkg::req_type px);
      int gap;
      gap = burst_send ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   // Stop offering, wait until every pixel sent has come back, then let the
   // pipeline settle so a register write cannot touch a word in flight.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (ledger.checked < sent) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three band registers, one per cycle, and mirror them.
   task automatic set_band(input int unsigned top, input int unsigned height,
                           input int unsigned softness);
      csr_we    <= 1'b1;
      csr_index <= tsb_pkg::REG_BAND_TOP;
      csr_wdata <= tsb_pkg::CSR_DATA_W'(top);
      @(posedge clock);
      csr_index <= tsb_pkg::REG_BAND_HEIGHT;
      csr_wdata <= tsb_pkg::CSR_DATA_W'(height);
      @(posedge clock);
      csr_index <= tsb_pkg::REG_SOFTNESS;
      csr_wdata <= tsb_pkg::CSR_DATA_W'(softness);
      @(posedge clock);
      csr_we <= 1'b0;
      ledger.band_top    = top & 32'hFFF;
      ledger.band_height = height & 32'h1FFF;
      ledger.softness    = softness & 32'h7F;
      settings++;
   endtask

   // -------------------------------------------------------------------------
   // Receiver: draws a stall before every word, or takes a long one-shot
   // hold-off when asked. Ready is only lowered when a stall follows.
   // -------------------------------------------------------------------------
   initial begin : receiver
      int stall;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off > 0) begin
            stall = hold_off;
            hold_off = 0;
            if (stall > longest_hold) begin
               longest_hold = stall;
            end
         end else begin
            stall = burst_recv ? 0 : $urandom_range(0, 10);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence: directed pixels first, then random band settings.
   // -------------------------------------------------------------------------
   initial begin : sender
      int unsigned top;
      int unsigned height;
      int unsigned softness;
      ledger = new();
      burst_send   = 1'b0;
      burst_recv   = 1'b0;
      hold_off     = 0;
      longest_hold = 0;
      sent         = 0;
      settings     = 1;
      backpressure = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= tsb_pkg::REG_BAND_TOP;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: band rows 0..20, softness 6. Center, edges, outside,
      // the far end of the frame, and alternating bit patterns.
      offer_pixel(pixel(10, 255, 255, 255, 0, 0, 0));
      offer_pixel(pixel(10, 0, 0, 0, 255, 255, 255));
      offer_pixel(pixel(0, 255, 0, 255, 0, 255, 0));
      offer_pixel(pixel(20, 200, 100, 50, 10, 20, 30));
      offer_pixel(pixel(30, 255, 255, 255, 0, 0, 0));
      offer_pixel(pixel(4095, 255, 255, 255, 0, 0, 0));
      offer_pixel(pixel(5, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
      offer_pixel(pixel(15, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
      quiesce();

      // Zero band height and zero softness: the weight collapses to zero.
      set_band(4095, 0, 0);
      offer_pixel(pixel(4095, 255, 255, 255, 0, 0, 0));
      offer_pixel(pixel(4094, 0, 128, 255, 255, 128, 0));
      offer_pixel(pixel(0, 255, 255, 255, 0, 0, 0));
      quiesce();

      // Widest register values: a band wider than the frame, softest edge.
      set_band(2048, 8191, 127);
      offer_pixel(pixel(0, 255, 255, 255, 0, 0, 0));
      offer_pixel(pixel(2048, 255, 255, 255, 0, 0, 0));
      offer_pixel(pixel(4095, 0, 0, 0, 255, 255, 255));
      offer_pixel(pixel(1024, 77, 33, 199, 5, 250, 128));
      quiesce();

      // A two-row band with the hardest edge.
      set_band(100, 2, 1);
      offer_pixel(pixel(99, 255, 255, 255, 0, 0, 0));
      offer_pixel(pixel(100, 255, 255, 255, 0, 0, 0));
      offer_pixel(pixel(101, 255, 255, 255, 0, 0, 0));
      offer_pixel(pixel(102, 255, 255, 255, 0, 0, 0));
      quiesce();

      // Largest nominal band from the top of the frame.
      set_band(0, 4096, 100);
      offer_pixel(pixel(0, 255, 0, 0, 0, 0, 255));
      offer_pixel(pixel(2048, 255, 0, 0, 0, 0, 255));
      offer_pixel(pixel(4095, 255, 0, 0, 0, 0, 255));
      quiesce();

      // Random band settings. The pacing changes from phase to phase so
      // that gaps land on every pipeline stage, with some phases running
      // flat out. Two phases hold the output off long enough to fill the
      // pipeline while the sender keeps offering.
      for (int ph = 0; ph < 12; ph++) begin
         top = $urandom_range(0, 4095);
         case ($urandom_range(0, 9))
            0: height = $urandom_range(0, 8191);
            1: height = 4096;
            default: height = $urandom_range(1, 200);
         endcase
         softness = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(1, 100);
         set_band(top, height, softness);
         burst_send = (ph % 4 == 1) || (ph % 4 == 2);
         burst_recv = (ph % 4 == 2) || (ph % 4 == 3);
         if (ph == 1 || ph == 5) begin
            burst_send = 1'b1;
            hold_off   = HOLD_OFF_CYCLES;
         end
         repeat (110) begin
            offer_pixel(pixel(pick_row(), chan(), chan(), chan(),
                              chan(), chan(), chan()));
         end
         quiesce();
      end

      if (ledger.blended_q.size() != 0) begin
         ledger.flag_mismatch($sformatf("%0d expected words never returned",
                                        ledger.blended_q.size()));
      end
      $display("Blended %0d pixels over %0d band settings, zero and widest registers included.",
               ledger.checked, settings);
      $display("Output held off up to %0d cycles; input refused on %0d cycles.",
               longest_hold, backpressure);
      if (ledger.mismatches == 0) begin
         $display("tilt_shift_blend regression: pass");
      end else begin
         $display("tilt_shift_blend regression: fail");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("tilt_shift_blend regression: fail");
      $finish;
   end

endmodule

// File: filelist.f
design/tsb_pkg.sv
design/tsb_tanh_lane.sv
design/tsb_mix.sv
design/tilt_shift_blend.sv
tb/tilt_shift_blend_tb.sv
